// ===== rtl/ppq_pkg.sv =====
package ppq_pkg;

	// fixed widths of the command and result fields
	localparam int CMD_W  = 2;
	localparam int PRIO_W = 8;
	localparam int TIME_W = 64;
	localparam int TAG_W  = 16;
	localparam int POS_W  = 4;
	localparam int HELD_W = 5;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

endpackage

// ===== rtl/ppq_store.sv =====
module ppq_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 88,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/ppq_cmp.sv =====
module ppq_cmp #(
	parameter int PB = 8,
	parameter int TB = 64
) (
	input  logic [PB-1:0] cand_prio,
	input  logic [TB-1:0] cand_time,
	input  logic [PB-1:0] best_prio,
	input  logic [TB-1:0] best_time,
	output logic          better
);

	// strict: on a full tie the earlier position keeps the lead
	assign better = (cand_prio > best_prio) ||
		((cand_prio == best_prio) && (cand_time < best_time));

endmodule

// ===== rtl/priority_pick_queue.sv =====
// channel   | ports                                                 | handshake
// ----------+-------------------------------------------------------+-----------------------
// command   | cmd priority_req time_key entry_tag entry_position    | start && !busy
// result    | status out_priority out_time_key out_tag out_position | done, one cycle
//           | entries_held                                          |
//
// Insert and rejected commands pass from accept through the decode state to done.
// Pop reads one held entry per cycle through the single store read port, then
// shifts later entries down one per cycle.
// Remove reads only the entry at its position, then shifts later entries down the same way.
// arst_n clears the count and sequencer; store contents are left as they are.
// busy stays high from accept until the done beat; results cannot be stalled.
module priority_pick_queue
	import ppq_pkg::*;
#(
	parameter int CAPACITY      = 16,
	parameter int PRIORITY_BITS = 8,
	parameter int TIME_BITS     = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [PRIO_W-1:0] priority_req,
	input  logic [TIME_W-1:0] time_key,
	input  logic [TAG_W-1:0]  entry_tag,
	input  logic [POS_W-1:0]  entry_position,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [PRIO_W-1:0] out_priority,
	output logic [TIME_W-1:0] out_time_key,
	output logic [TAG_W-1:0]  out_tag,
	output logic [POS_W-1:0]  out_position,
	output logic [HELD_W-1:0] entries_held
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int EW    = PRIORITY_BITS + TIME_BITS + TAG_W;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DECODE = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_SHIFT  = 2'd3;

	logic [1:0]         st_q;
	logic [CNT_W-1:0]   count_q;
	logic               done_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [POS_W-1:0]   pos_q;
	logic [EW-1:0]      ent_q;
	logic [EW-1:0]      best_q;
	logic [IDX_W-1:0]   bpos_q;
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   sh_q;
	logic [STAT_W-1:0]  status_q;
	logic [EW-1:0]      oent_q;
	logic [IDX_W-1:0]   opos_q;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [EW-1:0]      wr_data;
	logic [IDX_W-1:0]   rd_addr;
	logic [EW-1:0]      rd_data;

	logic               better;
	logic               is_rem;
	logic               take;
	logic               scan_fin;
	logic               is_full;
	logic               pos_ok;
	logic [IDX_W-1:0]   last_idx;
	logic [IDX_W-1:0]   sh_next;
	logic [EW-1:0]      sel_entry;
	logic [IDX_W-1:0]   sel_pos;

	ppq_store #(
		.DEPTH (CAPACITY),
		.WIDTH (EW),
		.AW    (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ppq_cmp #(
		.PB (PRIORITY_BITS),
		.TB (TIME_BITS)
	) u_cmp (
		.cand_prio (rd_data[EW-1 -: PRIORITY_BITS]),
		.cand_time (rd_data[TAG_W +: TIME_BITS]),
		.best_prio (best_q[EW-1 -: PRIORITY_BITS]),
		.best_time (best_q[TAG_W +: TIME_BITS]),
		.better    (better)
	);

	assign is_rem    = (cmd_q == CMD_REMOVE);
	assign is_full   = (count_q == CNT_W'(CAPACITY));
	assign pos_ok    = (CMP_W'(pos_q) < CMP_W'(count_q));
	assign last_idx  = IDX_W'(count_q - 1'b1);
	assign take      = is_rem || (cur_q == '0) || better;
	assign sel_entry = take ? rd_data : best_q;
	assign sel_pos   = take ? cur_q : bpos_q;
	assign scan_fin  = is_rem || (cur_q == last_idx);
	assign sh_next   = IDX_W'(sh_q + 1'b1);

	// store port steering
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = sh_q;
		wr_data = rd_data;
		rd_addr = cur_q;
		unique case (st_q)
			ST_IDLE: begin
			end
			ST_DECODE: begin
				if (cmd_q == CMD_INSERT && !is_full) begin
					wr_en   = 1'b1;
					wr_addr = IDX_W'(count_q);
					wr_data = ent_q;
				end
				rd_addr = is_rem ? IDX_W'(pos_q) : '0;
			end
			ST_SCAN: begin
				rd_addr = scan_fin ? IDX_W'(sel_pos + 1'b1) : IDX_W'(cur_q + 1'b1);
			end
			ST_SHIFT: begin
				// entry at sh_q+1 arrives now and drops one place
				wr_en   = 1'b1;
				wr_addr = sh_q;
				wr_data = rd_data;
				rd_addr = IDX_W'(sh_q + 2'd2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					unique case (cmd_q)
						CMD_INSERT: begin
							if (!is_full) begin
								count_q <= count_q + 1'b1;
							end
							st_q   <= ST_IDLE;
							done_q <= 1'b1;
						end
						CMD_POP: begin
							if (count_q == '0) begin
								st_q   <= ST_IDLE;
								done_q <= 1'b1;
							end else begin
								st_q <= ST_SCAN;
							end
						end
						CMD_REMOVE: begin
							if (!pos_ok) begin
								st_q   <= ST_IDLE;
								done_q <= 1'b1;
							end else begin
								st_q <= ST_SCAN;
							end
						end
						default: begin
							st_q   <= ST_IDLE;
							done_q <= 1'b1;
						end
					endcase
				end
				ST_SCAN: begin
					if (scan_fin) begin
						if (sel_pos == last_idx) begin
							count_q <= count_q - 1'b1;
							st_q    <= ST_IDLE;
							done_q  <= 1'b1;
						end else begin
							st_q <= ST_SHIFT;
						end
					end
				end
				ST_SHIFT: begin
					if (sh_next == last_idx) begin
						count_q <= count_q - 1'b1;
						st_q    <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload and sequencing registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				if (start) begin
					cmd_q <= cmd;
					pos_q <= entry_position;
					ent_q <= {PRIORITY_BITS'(priority_req), TIME_BITS'(time_key), entry_tag};
				end
			end
			ST_DECODE: begin
				status_q <= STAT_OK;
				oent_q   <= '0;
				opos_q   <= '0;
				cur_q    <= is_rem ? IDX_W'(pos_q) : '0;
				unique case (cmd_q)
					CMD_INSERT: begin
						if (is_full) begin
							status_q <= STAT_FULL;
						end
					end
					CMD_POP: begin
						if (count_q == '0) begin
							status_q <= STAT_EMPTY;
						end
					end
					CMD_REMOVE: begin
						if (!pos_ok) begin
							status_q <= STAT_BADPOS;
						end
					end
					default: begin
					end
				endcase
			end
			ST_SCAN: begin
				best_q <= sel_entry;
				bpos_q <= sel_pos;
				cur_q  <= IDX_W'(cur_q + 1'b1);
				if (scan_fin) begin
					oent_q <= sel_entry;
					opos_q <= sel_pos;
					sh_q   <= sel_pos;
				end
			end
			ST_SHIFT: begin
				sh_q <= sh_next;
			end
			default: begin
			end
		endcase
	end

	assign busy         = (st_q != ST_IDLE);
	assign done         = done_q;
	assign status       = status_q;
	assign out_priority = PRIO_W'(oent_q[EW-1 -: PRIORITY_BITS]);
	assign out_time_key = TIME_W'(oent_q[TAG_W +: TIME_BITS]);
	assign out_tag      = oent_q[TAG_W-1:0];
	assign out_position = POS_W'(opos_q);
	assign entries_held = HELD_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(CAPACITY) >= count_q)
		else $error("held count above capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STAT_EMPTY) |-> (count_q == '0))
		else $error("empty flagged with entries held");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == STAT_FULL) |-> (count_q == CNT_W'(CAPACITY)))
		else $error("full flagged below capacity");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SHIFT) |-> (CNT_W'(sh_q) + 1'b1 < count_q))
		else $error("shift source beyond held entries");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (st_q == ST_IDLE && $past(st_q) != ST_IDLE))
		else $error("done beat outside command completion");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
	import ppq_pkg::*;
();

	localparam int Q_DEPTH    = 16;
	localparam int N_RANDOM   = 775;
	localparam int STALL_MAX  = 2000;
	localparam int TAIL_WAIT  = 60;
	localparam int CALM_FIRST = 300;
	localparam int CALM_LAST  = 460;

	// opcode the block ignores; it still returns one beat
	localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]  op;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] tkey;
		logic [TAG_W-1:0]  tag;
		logic [POS_W-1:0]  pos;
	} ppq_cmd_t;

	typedef struct {
		logic [STAT_W-1:0] stat;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] tkey;
		logic [TAG_W-1:0]  tag;
		logic [POS_W-1:0]  pos;
		logic [HELD_W-1:0] held;
	} ppq_res_t;

	logic              clk            = 1'b0;
	logic              arst_n         = 1'b0;
	logic              start          = 1'b0;
	logic [CMD_W-1:0]  cmd            = '0;
	logic [PRIO_W-1:0] priority_req   = '0;
	logic [TIME_W-1:0] time_key       = '0;
	logic [TAG_W-1:0]  entry_tag      = '0;
	logic [POS_W-1:0]  entry_position = '0;
	logic              busy;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [PRIO_W-1:0] out_priority;
	logic [TIME_W-1:0] out_time_key;
	logic [TAG_W-1:0]  out_tag;
	logic [POS_W-1:0]  out_position;
	logic [HELD_W-1:0] entries_held;

	priority_pick_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.priority_req  (priority_req),
		.time_key      (time_key),
		.entry_tag     (entry_tag),
		.entry_position(entry_position),
		.done          (done),
		.status        (status),
		.out_priority  (out_priority),
		.out_time_key  (out_time_key),
		.out_tag       (out_tag),
		.out_position  (out_position),
		.entries_held  (entries_held)
	);

	always #5 clk = ~clk;

	ppq_cmd_t pending_cmds[$];
	ppq_res_t awaited_results[$];
	ppq_cmd_t cur_cmd;
	int       cmds_taken = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	logic     timed_out = 1'b0;
	int       gen_held = 0;

	// shadow of the store contents
	logic [PRIO_W-1:0] shadow_prio[Q_DEPTH];
	logic [TIME_W-1:0] shadow_tkey[Q_DEPTH];
	logic [TAG_W-1:0]  shadow_tag[Q_DEPTH];
	int                shadow_held = 0;

	function automatic ppq_res_t serve_command(ppq_cmd_t c);
		ppq_res_t r;
		int       victim;
		r = '{default: '0};
		victim = -1;
		case (c.op)
			CMD_INSERT: begin
				if (shadow_held >= Q_DEPTH) begin
					r.stat = STAT_FULL;
				end else begin
					shadow_prio[shadow_held] = c.prio;
					shadow_tkey[shadow_held] = c.tkey;
					shadow_tag[shadow_held]  = c.tag;
					shadow_held++;
				end
			end
			CMD_POP: begin
				if (shadow_held == 0) begin
					r.stat = STAT_EMPTY;
				end else begin
					victim = 0;
					// strict compares keep the lowest position on a full tie
					for (int i = 1; i < shadow_held; i++)
						if (shadow_prio[i] > shadow_prio[victim] ||
						    (shadow_prio[i] == shadow_prio[victim] &&
						     shadow_tkey[i] < shadow_tkey[victim]))
							victim = i;
				end
			end
			CMD_REMOVE: begin
				if (int'(c.pos) >= shadow_held)
					r.stat = STAT_BADPOS;
				else
					victim = int'(c.pos);
			end
			default: ;
		endcase
		if (victim >= 0) begin
			r.prio = shadow_prio[victim];
			r.tkey = shadow_tkey[victim];
			r.tag  = shadow_tag[victim];
			r.pos  = POS_W'(victim);
			for (int i = victim; i < shadow_held - 1; i++) begin
				shadow_prio[i] = shadow_prio[i + 1];
				shadow_tkey[i] = shadow_tkey[i + 1];
				shadow_tag[i]  = shadow_tag[i + 1];
			end
			shadow_held--;
		end
		r.held = HELD_W'(shadow_held);
		return r;
	endfunction

	// gen_held follows the count so removes mostly hit held positions
	function automatic void queue_cmd(logic [CMD_W-1:0] op, logic [PRIO_W-1:0] prio,
			logic [TIME_W-1:0] tkey, logic [TAG_W-1:0] tag, logic [POS_W-1:0] pos);
		ppq_cmd_t c;
		c = '{op: op, prio: prio, tkey: tkey, tag: tag, pos: pos};
		pending_cmds.push_back(c);
		if (op == CMD_INSERT && gen_held < Q_DEPTH)
			gen_held++;
		else if (op == CMD_POP && gen_held > 0)
			gen_held--;
		else if (op == CMD_REMOVE && int'(pos) < gen_held)
			gen_held--;
	endfunction

	task automatic flag_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// driver: start held until the beat is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				awaited_results.push_back(serve_command(cur_cmd));
				cmds_taken++;
			end
			if (!(start && busy)) begin
				if (pending_cmds.size() > 0 &&
				    ((cmds_taken >= CALM_FIRST && cmds_taken < CALM_LAST) ||
				     $urandom_range(0, 99) >= 38)) begin
					cur_cmd = pending_cmds.pop_front();
					cmd            <= cur_cmd.op;
					priority_req   <= cur_cmd.prio;
					time_key       <= cur_cmd.tkey;
					entry_tag      <= cur_cmd.tag;
					entry_position <= cur_cmd.pos;
					start          <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		ppq_res_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("result beat with nothing outstanding");
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.stat)
					flag_mismatch($sformatf("status %0d, want %0d", status, want.stat));
				if (out_priority !== want.prio)
					flag_mismatch($sformatf("out_priority %0d, want %0d",
						out_priority, want.prio));
				if (out_time_key !== want.tkey)
					flag_mismatch($sformatf("out_time_key %h, want %h",
						out_time_key, want.tkey));
				if (out_tag !== want.tag)
					flag_mismatch($sformatf("out_tag %h, want %h", out_tag, want.tag));
				if (out_position !== want.pos)
					flag_mismatch($sformatf("out_position %0d, want %0d",
						out_position, want.pos));
				if (entries_held !== want.held)
					flag_mismatch($sformatf("entries_held %0d, want %0d",
						entries_held, want.held));
			end
		end
	end

	// watchdog on cycles with no beat either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_MAX)
			timed_out <= 1'b1;
	end

	initial begin
		int                op_roll;
		int                ins_pct;
		logic [CMD_W-1:0]  op;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] tkey;
		logic [POS_W-1:0]  pos;

		// directed: empty cases, ignored opcode, fill with extremes and ties, then pops and removes
		queue_cmd(CMD_POP, '0, '0, '0, '0);
		queue_cmd(CMD_REMOVE, '0, '0, '0, '0);
		queue_cmd(CMD_IGNORED, '1, '1, '1, '1);
		queue_cmd(CMD_INSERT, 8'd0, 64'd0, 16'h0000, '0);
		queue_cmd(CMD_INSERT, 8'd255, '1, 16'hffff, '0);
		queue_cmd(CMD_INSERT, 8'd255, 64'd5, 16'h1111, '0);
		queue_cmd(CMD_INSERT, 8'd255, 64'd5, 16'h2222, '0);
		queue_cmd(CMD_INSERT, 8'd7, 64'h3038_3a30_303a_3030, 16'h0707, '0);
		queue_cmd(CMD_INSERT, 8'd7, 64'h3037_3a35_393a_3539, 16'h0708, '0);
		for (int i = 0; i < 10; i++)
			queue_cmd(CMD_INSERT, 8'(i * 23), {$urandom, $urandom},
				16'($urandom), '0);
		queue_cmd(CMD_INSERT, 8'd200, 64'd1, 16'hbeef, '0);
		queue_cmd(CMD_REMOVE, '0, '0, '0, 4'd15);
		queue_cmd(CMD_POP, '0, '0, '0, '0);
		queue_cmd(CMD_REMOVE, '0, '0, '0, 4'd0);
		queue_cmd(CMD_REMOVE, '0, '0, '0, 4'd14);
		queue_cmd(CMD_POP, '0, '0, '0, '0);

		// random: alternate filling and draining spells so full and empty recur
		for (int k = 0; k < N_RANDOM; k++) begin
			ins_pct = ((k / 40) % 2 == 0) ? 65 : 30;
			op_roll = $urandom_range(0, 99);
			if (op_roll < 3)
				op = CMD_IGNORED;
			else if (op_roll < 3 + ins_pct)
				op = CMD_INSERT;
			else if (op_roll % 2 == 0)
				op = CMD_POP;
			else
				op = CMD_REMOVE;
			case ($urandom_range(0, 9))
				0:       prio = '1;
				1:       prio = '0;
				2, 3, 4: prio = 8'($urandom_range(0, 3));
				default: prio = 8'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0:          tkey = '1;
				1:          tkey = '0;
				2, 3, 4, 5: tkey = 64'($urandom_range(0, 3));
				default:    tkey = {$urandom, $urandom};
			endcase
			if (gen_held > 0 && $urandom_range(0, 99) < 80)
				pos = POS_W'($urandom_range(0, gen_held - 1));
			else
				pos = POS_W'($urandom_range(0, 15));
			queue_cmd(op, prio, tkey, 16'($urandom), pos);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		@(posedge clk);
		while (!timed_out &&
		       (pending_cmds.size() != 0 || start || awaited_results.size() != 0))
			@(posedge clk);
		if (!timed_out)
			repeat (TAIL_WAIT) @(posedge clk);

		if (mismatches == 0 && !timed_out && awaited_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ppq_pkg.sv
rtl/ppq_store.sv
rtl/ppq_cmp.sv
rtl/priority_pick_queue.sv
tb/tb_top.sv
